// ----- hw/rtl/imm_pkg.sv -----
// imm_pkg: shared types and constants for the integer matrix multiply core.
// Beat payload structs, controller/datapath command and status, register indexes.
// No dependencies.
package imm_pkg;

    localparam int OPERAND_W = 32;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_OUT_W = 4;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_READ   = 2'd2
    } imm_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A = 2'd0,
        CFG_COLS_A = 2'd1,
        CFG_ROWS_B = 2'd2,
        CFG_COLS_B = 2'd3
    } imm_cfg_idx_t;

    typedef struct packed {
        logic [1:0]                  operation;
        logic signed [OPERAND_W-1:0] element_value;
    } imm_in_t;

    typedef struct packed {
        logic signed [OPERAND_W-1:0] product_value;
        logic [IDX_OUT_W-1:0]        row_index;
        logic [IDX_OUT_W-1:0]        col_index;
        logic                        last_element;
        logic                        size_error;
    } imm_out_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
        logic issue;
        logic out_load;
        logic err_load;
    } imm_cmd_t;

    typedef struct packed {
        logic size_error;
        logic issue_last;
        logic pipe_idle;
        logic out_free;
    } imm_stat_t;

endpackage

// ----- hw/rtl/imm_ram.sv -----
// imm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/imm_ctrl.sv -----
// imm_ctrl: sequencer for loads, MAC issue, pipeline drain and result handoff.
// Depends on imm_pkg (command/status structs, operation codes).
module imm_ctrl
    import imm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] operation,
    input  imm_stat_t  stat,
    output imm_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_ERR
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (operation)
                        OP_LOAD_A: cmd.load_a = 1'b1;
                        OP_LOAD_B: cmd.load_b = 1'b1;
                        OP_READ: begin
                            if (stat.size_error) begin
                                state_next = ST_ERR;
                            end else begin
                                cmd.start  = 1'b1;
                                state_next = ST_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                if (stat.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (stat.pipe_idle && stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (stat.out_free) begin
                    cmd.err_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// ----- hw/rtl/imm_datapath.sv -----
// imm_datapath: dimension registers, A/B stores, load and read pointers,
// MAC pipeline (RAM read, multiply, accumulate) and output register.
// Depends on imm_pkg and imm_ram.
module imm_datapath
    import imm_pkg::*;
#(
    parameter int MAX_DIM    = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  imm_in_t              s_payload,
    input  imm_cmd_t             cmd,
    output imm_stat_t            stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output imm_out_t             m_payload
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int IW    = $clog2(MAX_DIM);

    function automatic logic [DW-1:0] dim_of(input logic [CFG_W-1:0] r);
        logic [DW-1:0] d;
        if (r == '0) begin
            d = DW'(1);
        end else if (32'(r) > MAX_DIM) begin
            d = DW'(MAX_DIM);
        end else begin
            d = DW'(r);
        end
        return d;
    endfunction

    logic [CFG_W-1:0] rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg;
    logic [DW-1:0]    ra, ca, rb, cb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg <= CFG_W'(1);
            cols_a_reg <= CFG_W'(1);
            rows_b_reg <= CFG_W'(1);
            cols_b_reg <= CFG_W'(1);
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_ROWS_A: rows_a_reg <= cfg_wdata;
                CFG_COLS_A: cols_a_reg <= cfg_wdata;
                CFG_ROWS_B: rows_b_reg <= cfg_wdata;
                CFG_COLS_B: cols_b_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign ra = dim_of(rows_a_reg);
    assign ca = dim_of(cols_a_reg);
    assign rb = dim_of(rows_b_reg);
    assign cb = dim_of(cols_b_reg);

    // load pointers
    logic [CW-1:0] cnt_a, cnt_b;
    logic [AW-1:0] load_a_ptr_reg, load_a_ptr_next, load_b_ptr_reg, load_b_ptr_next;
    logic [AW-1:0] a_waddr, b_waddr;
    logic [CW-1:0] a_inc, b_inc;

    assign cnt_a   = CW'(ra) * CW'(ca);
    assign cnt_b   = CW'(rb) * CW'(cb);
    assign a_waddr = (CW'(load_a_ptr_reg) >= cnt_a) ? '0 : load_a_ptr_reg;
    assign b_waddr = (CW'(load_b_ptr_reg) >= cnt_b) ? '0 : load_b_ptr_reg;
    assign a_inc   = CW'(a_waddr) + CW'(1);
    assign b_inc   = CW'(b_waddr) + CW'(1);
    assign load_a_ptr_next = (a_inc >= cnt_a) ? '0 : AW'(a_inc);
    assign load_b_ptr_next = (b_inc >= cnt_b) ? '0 : AW'(b_inc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_a_ptr_reg <= '0;
            load_b_ptr_reg <= '0;
        end else begin
            if (cmd.load_a) load_a_ptr_reg <= load_a_ptr_next;
            if (cmd.load_b) load_b_ptr_reg <= load_b_ptr_next;
        end
    end

    // stores
    logic [AW-1:0]         a_raddr_reg, b_raddr_reg;
    logic [ELEM_WIDTH-1:0] a_rdata, b_rdata;

    imm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_a (
        .aclk  (aclk),
        .we    (cmd.load_a),
        .waddr (a_waddr),
        .wdata (s_payload.element_value[ELEM_WIDTH-1:0]),
        .raddr (a_raddr_reg),
        .rdata (a_rdata)
    );

    imm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_b (
        .aclk  (aclk),
        .we    (cmd.load_b),
        .waddr (b_waddr),
        .wdata (s_payload.element_value[ELEM_WIDTH-1:0]),
        .raddr (b_raddr_reg),
        .rdata (b_rdata)
    );

    // read position
    logic [IW-1:0] read_row_reg, read_col_reg, cur_row_reg, cur_col_reg;
    logic [IW-1:0] row_eff, col_eff, row_adv, col_adv;
    logic [DW-1:0] row_inc, col_inc;
    logic          out_of_range, is_last;
    logic [IW-1:0] k_reg;

    assign out_of_range = (DW'(read_row_reg) >= ra) || (DW'(read_col_reg) >= cb);
    assign row_eff      = out_of_range ? '0 : read_row_reg;
    assign col_eff      = out_of_range ? '0 : read_col_reg;
    assign row_inc      = DW'(cur_row_reg) + DW'(1);
    assign col_inc      = DW'(cur_col_reg) + DW'(1);
    assign is_last      = (row_inc == ra) && (col_inc == cb);

    always_comb begin
        row_adv = cur_row_reg;
        col_adv = IW'(col_inc);
        if (col_inc >= cb) begin
            col_adv = '0;
            row_adv = (row_inc >= ra) ? '0 : IW'(row_inc);
        end
    end

    // MAC pipeline
    logic                 rd_v_reg, mul_v_reg;
    logic [OPERAND_W-1:0] a_ext, b_ext, mul_reg, acc_reg;

    assign a_ext = OPERAND_W'(signed'(a_rdata));
    assign b_ext = OPERAND_W'(signed'(b_rdata));

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            cur_row_reg <= row_eff;
            cur_col_reg <= col_eff;
            a_raddr_reg <= AW'(AW'(row_eff) * AW'(ca));
            b_raddr_reg <= AW'(col_eff);
            k_reg       <= '0;
        end else if (cmd.issue) begin
            a_raddr_reg <= a_raddr_reg + AW'(1);
            b_raddr_reg <= b_raddr_reg + AW'(cb);
            k_reg       <= k_reg + IW'(1);
        end
        mul_reg <= a_ext * b_ext;
        if (cmd.start) begin
            acc_reg <= '0;
        end else if (mul_v_reg) begin
            acc_reg <= acc_reg + mul_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg     <= 1'b0;
            mul_v_reg    <= 1'b0;
            read_row_reg <= '0;
            read_col_reg <= '0;
        end else begin
            rd_v_reg  <= cmd.issue;
            mul_v_reg <= rd_v_reg;
            if (cmd.out_load) begin
                read_row_reg <= row_adv;
                read_col_reg <= col_adv;
            end
        end
    end

    // output register
    logic     m_valid_reg;
    imm_out_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load || cmd.err_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.product_value <= acc_reg;
            out_reg.row_index     <= IDX_OUT_W'(cur_row_reg);
            out_reg.col_index     <= IDX_OUT_W'(cur_col_reg);
            out_reg.last_element  <= is_last;
            out_reg.size_error    <= 1'b0;
        end else if (cmd.err_load) begin
            out_reg <= '{product_value: '0,
                         row_index:     '0,
                         col_index:     '0,
                         last_element:  1'b0,
                         size_error:    1'b1};
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    assign stat.size_error = (cols_a_reg != rows_b_reg);
    assign stat.issue_last = (DW'(k_reg) == ca - DW'(1));
    assign stat.pipe_idle  = !rd_v_reg && !mul_v_reg;
    assign stat.out_free   = !m_valid_reg || m_ready;

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load || cmd.err_load) |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending beat");

    a_acc_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!rd_v_reg && !mul_v_reg))
        else $error("result taken before accumulation finished");

    a_k_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> (DW'(k_reg) < ca))
        else $error("MAC issue beyond inner dimension");

    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> (acc_reg == '0))
        else $error("accumulator not cleared at start");

endmodule

// ----- hw/rtl/integer_matrix_multiply_core.sv -----
// integer_matrix_multiply_core: A*B with both matrices held in on-chip RAM.
// A read beat runs one MAC per inner-dimension step on a single multiplier,
// through RAM read, multiply and accumulate stages. Results sit in an output
// register; loads proceed while one waits. aresetn (synchronous, active low)
// sets all dimensions to 1 and clears pointers and read position; matrix
// contents are undefined until loaded.
module integer_matrix_multiply_core
    import imm_pkg::*;
#(
    parameter int MAX_DIM    = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  imm_in_t              s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output imm_out_t             m_payload
);

    imm_cmd_t  cmd;
    imm_stat_t stat;

    imm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .operation (s_payload.operation),
        .stat      (stat),
        .cmd       (cmd)
    );

    imm_datapath #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_payload (s_payload),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule
